// ===== hdl/tv_denoise_1d_top_macros.svh =====
// Assertion macros shared by the denoiser top level.
`ifndef TV_DENOISE_1D_TOP_MACROS_SVH
`define TV_DENOISE_1D_TOP_MACROS_SVH
// Same-cycle implication under the active-low reset.
`define TVD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under the active-low reset.
`define TVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/tvd_pkg.sv =====
// Package with widths, constants, sequencer types and rounding for the denoiser.
`timescale 1ns / 1ps
package tvd_pkg;
  localparam int SAMPLE_W = 14;
  localparam int OUT_W = 22;
  localparam int IDX_W = 12;
  localparam int VAL_W = 40;
  localparam int FRAC_W = 16;
  localparam int DEF_MAX_SAMPLES = 4096;
  localparam logic [OUT_W-1:0] OUT_MAX = 22'h3FFFFF;
  localparam logic [SAMPLE_W-1:0] LAMBDA_RESET = 14'd50;

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_INIT, S_LOOP, S_STEP1, S_STEP2, S_CHK1, S_DIV1,
    S_CHK2, S_DIV2, S_FDIV, S_PUT, S_RESTART
  } eng_state_e;

  typedef enum logic [2:0] {
    RK_END_MIN, RK_END_MAX, RK_JUMP_MIN, RK_JUMP_MAX, RK_FINAL
  } restart_kind_e;

  // Round a Q.16 value to 8 fractional bits and clamp to the output range.
  function automatic logic [OUT_W-1:0] round_out(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    logic [VAL_W-9:0] q;
    r = v + VAL_W'(128);
    q = r[VAL_W-1:8];
    if (r < 0) return '0;
    if (q > (VAL_W-8)'(OUT_MAX)) return OUT_MAX;
    return q[OUT_W-1:0];
  endfunction
endpackage

// ===== hdl/tvd_in_if.sv =====
// Input and output channel interfaces of the denoiser.
`timescale 1ns / 1ps
interface tvd_in_if;
  import tvd_pkg::*;
  logic valid;
  logic ready;
  logic command;
  logic [SAMPLE_W-1:0] sample_in;
  logic last_sample;
  logic [IDX_W-1:0] read_index;
  modport source (output valid, command, sample_in, last_sample, read_index, input ready);
  modport sink (input valid, command, sample_in, last_sample, read_index, output ready);
endinterface

interface tvd_out_if;
  import tvd_pkg::*;
  logic valid;
  logic ready;
  logic [OUT_W-1:0] denoised_value;
  logic read_error;
  modport source (output valid, denoised_value, read_error, input ready);
  modport sink (input valid, denoised_value, read_error, output ready);
endinterface

// ===== hdl/tv_denoise_1d_top.sv =====
// Top level of the one-dimensional total variation denoiser.
// Channel   Direction  Transfer carries
// in_i      sink       command, sample_in, last_sample, read_index
// out_o     source     denoised_value, read_error (one per read command)
// lambda    write      lambda_wdata_i when lambda_we_i is high
// A load is stored while room is left; a read's result comes in the next cycle.
// The load flagged last starts the taut-string pass, which holds in_i.ready low
// until every result is written; each division by segment length runs on the
// shared bit-serial divider.
// Reset clears the sample count, the done flag and the output slot; the stores
// need no clearing. A stalled result is held while no new transfer is taken.
`timescale 1ns / 1ps
`include "tv_denoise_1d_top_macros.svh"
module tv_denoise_1d_top
  import tvd_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tvd_in_if.sink              in_i,
  tvd_out_if.source           out_o,
  input  logic                lambda_we_i,
  input  logic [SAMPLE_W-1:0] lambda_wdata_i
);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  logic [SAMPLE_W-1:0] lambda_q;
  logic [CW-1:0] count_q, count_d, count_eff;
  logic done_q, done_d;
  logic out_valid_q, out_valid_d, err_q, err_d;
  logic busy, start, load_acc, read_acc, raw_we;
  logic [AW-1:0] raw_raddr, sm_waddr;
  logic [SAMPLE_W-1:0] raw_rdata;
  logic sm_we;
  logic [OUT_W-1:0] sm_wdata, sm_rdata;
  logic [XW-1:0] idx_ext;

  // A new transfer is taken once the pass is over and the output slot frees up.
  assign in_i.ready = !busy && (!out_valid_q || out_o.ready);
  assign load_acc = in_i.valid && in_i.ready && !in_i.command;
  assign read_acc = in_i.valid && in_i.ready && in_i.command;

  // A load after a finished waveform starts a new one from position zero.
  assign count_eff = done_q ? '0 : count_q;
  assign raw_we = load_acc && (count_eff < CW'(MAX_SAMPLES));
  assign idx_ext = XW'(in_i.read_index);

  always_comb begin
    count_d = count_q;
    done_d = done_q;
    out_valid_d = out_valid_q && !out_o.ready;
    err_d = err_q;
    if (load_acc) begin
      count_d = raw_we ? count_eff + CW'(1) : count_eff;
      done_d = in_i.last_sample;
    end
    if (read_acc) begin
      out_valid_d = 1'b1;
      err_d = !done_q || (idx_ext >= XW'(count_q));
    end
  end

  assign start = load_acc && in_i.last_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= LAMBDA_RESET;
      count_q <= '0;
      done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (lambda_we_i) lambda_q <= lambda_wdata_i;
      count_q <= count_d;
      done_q <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
  end

  tvd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_raw (
    .clk_i   (clk_i),
    .we_i    (raw_we),
    .waddr_i (count_eff[AW-1:0]),
    .wdata_i (in_i.sample_in),
    .re_i    (1'b1),
    .raddr_i (raw_raddr),
    .rdata_o (raw_rdata)
  );

  tvd_ram #(.WIDTH(OUT_W), .DEPTH(MAX_SAMPLES)) u_smooth (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .re_i    (read_acc),
    .raddr_i (idx_ext[AW-1:0]),
    .rdata_o (sm_rdata)
  );

  tvd_engine #(.MAX_SAMPLES(MAX_SAMPLES)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .n_i         (count_d),
    .lambda_i    (lambda_q),
    .raw_raddr_o (raw_raddr),
    .raw_rdata_i (raw_rdata),
    .sm_we_o     (sm_we),
    .sm_waddr_o  (sm_waddr),
    .sm_wdata_o  (sm_wdata),
    .busy_o      (busy)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.read_error = err_q;
  assign out_o.denoised_value = err_q ? '0 : sm_rdata;

  `TVD_ASSERT_NOW(a_no_take_busy, clk_i, rst_ni, busy, !in_i.ready, "transfer offered during pass")
  `TVD_ASSERT_NEXT(a_last_starts, clk_i, rst_ni, start, busy, "last sample did not start the pass")
  `TVD_ASSERT_NEXT(a_read_result, clk_i, rst_ni, read_acc, out_o.valid, "read produced no result")
endmodule

// ===== hdl/tvd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/tvd_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps
module tvd_div
  import tvd_pkg::*;
#(
  parameter int DEN_W = 13
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [VAL_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] quot_o
);
  localparam int CNT_W = $clog2(VAL_W + 1);

  logic [VAL_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic neg_q, done_q, done_d;
  logic [DEN_W:0] shifted;

  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    shifted = {rem_q, acc_q[VAL_W-1]};
    if (start_i) begin
      acc_d = num_i[VAL_W-1] ? VAL_W'(-num_i) : VAL_W'(num_i);
      rem_d = '0;
      cnt_d = CNT_W'(VAL_W);
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = DEN_W'(shifted - {1'b0, den_q});
        acc_d = {acc_q[VAL_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DEN_W-1:0];
        acc_d = {acc_q[VAL_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (start_i) begin
      neg_q <= num_i[VAL_W-1];
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -signed'(acc_q) : signed'(acc_q);
endmodule

// ===== hdl/tvd_engine.sv =====
// Taut-string sequencer that walks the raw store and fills the smooth store.
`timescale 1ns / 1ps
module tvd_engine
  import tvd_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0] n_i,
  input  logic [SAMPLE_W-1:0]              lambda_i,
  output logic [$clog2(MAX_SAMPLES)-1:0]   raw_raddr_o,
  input  logic [SAMPLE_W-1:0]              raw_rdata_i,
  output logic                             sm_we_o,
  output logic [$clog2(MAX_SAMPLES)-1:0]   sm_waddr_o,
  output logic [OUT_W-1:0]                 sm_wdata_o,
  output logic                             busy_o
);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);

  eng_state_e state_q, state_d;
  restart_kind_e kind_q;
  logic [CW-1:0] n_q, k_q, k0_q, kp_q, km_q, lim_q;
  logic signed [VAL_W-1:0] umin_q, umax_q, vmin_q, vmax_q, pv_q, f_q;
  logic signed [VAL_W-1:0] lam, fetch, t1, t2, quot, div_num;
  logic [CW-1:0] k_inc, k0_inc, seg_len;
  logic div_start, div_done;

  assign lam = signed'({{(VAL_W-SAMPLE_W-FRAC_W){1'b0}}, lambda_i, {FRAC_W{1'b0}}});
  assign fetch = signed'({{(VAL_W-SAMPLE_W-FRAC_W){1'b0}}, raw_rdata_i, {FRAC_W{1'b0}}});
  assign k_inc = k_q + CW'(1);
  assign k0_inc = k0_q + CW'(1);
  assign seg_len = k_q - k0_q + CW'(1);
  assign t1 = umin_q + fetch - vmin_q;
  assign t2 = umax_q + f_q - vmax_q;

  tvd_div #(.DEN_W(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (seg_len),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Next state. The wait state lets the last sample's write land before the
  // first sample is read, which matters for a one-sample waveform.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (start_i) state_d = S_WAIT;
      S_WAIT:    state_d = S_INIT;
      S_INIT:    state_d = S_LOOP;
      S_LOOP: begin
        if (k_inc == n_q) begin
          if (umin_q < 0 || umax_q > 0) state_d = S_PUT;
          else state_d = S_FDIV;
        end else begin
          state_d = S_STEP1;
        end
      end
      S_STEP1:   state_d = (t1 < -lam) ? S_PUT : S_STEP2;
      S_STEP2:   state_d = (t2 > lam) ? S_PUT : S_CHK1;
      S_CHK1:    state_d = (umin_q >= lam) ? S_DIV1 : S_CHK2;
      S_DIV1:    if (div_done) state_d = S_CHK2;
      S_CHK2:    state_d = (umax_q <= -lam) ? S_DIV2 : S_LOOP;
      S_DIV2:    if (div_done) state_d = S_LOOP;
      S_FDIV:    if (div_done) state_d = S_PUT;
      S_PUT: begin
        if (k0_inc <= lim_q && k0_inc < n_q) state_d = S_PUT;
        else if (k0_inc >= n_q) state_d = S_IDLE;
        else state_d = S_RESTART;
      end
      S_RESTART: state_d = S_LOOP;
      default:   state_d = S_IDLE;
    endcase
  end

  // Outputs toward the stores and the divider.
  always_comb begin
    raw_raddr_o = '0;
    div_start = 1'b0;
    div_num = umin_q;
    sm_we_o = 1'b0;
    unique case (state_q)
      S_LOOP: begin
        raw_raddr_o = k_inc[AW-1:0];
        div_start = (k_inc == n_q) && !(umin_q < 0) && !(umax_q > 0);
      end
      S_CHK1: begin
        div_num = umin_q - lam;
        div_start = (umin_q >= lam);
      end
      S_CHK2: begin
        div_num = umax_q + lam;
        div_start = (umax_q <= -lam);
      end
      S_PUT: begin
        sm_we_o = 1'b1;
        raw_raddr_o = k0_inc[AW-1:0];
      end
      default: ;
    endcase
  end

  assign sm_waddr_o = k0_q[AW-1:0];
  assign sm_wdata_o = round_out(pv_q);
  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        n_q <= n_i;
        k_q <= '0; k0_q <= '0; kp_q <= '0; km_q <= '0;
      end
      S_INIT: begin
        vmin_q <= fetch - lam;
        vmax_q <= fetch + lam;
        umin_q <= lam;
        umax_q <= -lam;
      end
      S_LOOP: begin
        if (k_inc == n_q) begin
          if (umin_q < 0) begin
            pv_q <= vmin_q; lim_q <= km_q; kind_q <= RK_END_MIN;
          end else if (umax_q > 0) begin
            pv_q <= vmax_q; lim_q <= kp_q; kind_q <= RK_END_MAX;
          end
        end
      end
      S_STEP1: begin
        f_q <= fetch;
        if (t1 < -lam) begin
          pv_q <= vmin_q; lim_q <= km_q; kind_q <= RK_JUMP_MIN;
        end else begin
          umin_q <= t1;
        end
      end
      S_STEP2: begin
        if (t2 > lam) begin
          pv_q <= vmax_q; lim_q <= kp_q; kind_q <= RK_JUMP_MAX;
        end else begin
          umax_q <= t2;
          k_q <= k_inc;
        end
      end
      S_CHK1: if (umin_q >= lam) km_q <= k_q;
      S_DIV1: if (div_done) begin
        vmin_q <= vmin_q + quot;
        umin_q <= lam;
      end
      S_CHK2: if (umax_q <= -lam) kp_q <= k_q;
      S_DIV2: if (div_done) begin
        vmax_q <= vmax_q + quot;
        umax_q <= -lam;
      end
      S_FDIV: if (div_done) begin
        pv_q <= vmin_q + quot;
        lim_q <= k_q;
        kind_q <= RK_FINAL;
      end
      S_PUT: k0_q <= k0_inc;
      S_RESTART: begin
        case (kind_q)
          RK_END_MIN: begin
            k_q <= k0_q; km_q <= k0_q;
            vmin_q <= fetch; umin_q <= lam;
            umax_q <= fetch + lam - vmax_q;
          end
          RK_END_MAX: begin
            k_q <= k0_q; kp_q <= k0_q;
            vmax_q <= fetch; umax_q <= -lam;
            umin_q <= fetch - lam - vmin_q;
          end
          RK_JUMP_MIN: begin
            k_q <= k0_q; km_q <= k0_q; kp_q <= k0_q;
            vmin_q <= fetch; vmax_q <= fetch + (lam <<< 1);
            umin_q <= lam; umax_q <= -lam;
          end
          default: begin
            k_q <= k0_q; km_q <= k0_q; kp_q <= k0_q;
            vmax_q <= fetch; vmin_q <= fetch - (lam <<< 1);
            umin_q <= lam; umax_q <= -lam;
          end
        endcase
      end
      default: ;
    endcase
  end
endmodule
